// ===== src/wfd_pkg.sv =====
// Package of shared types and constants for the WAV frame decode and downmix block.
`timescale 1ns / 1ps
package wfd_pkg;

  localparam int SLOT_W   = 64;
  localparam int SLOTS    = 8;
  localparam int SAMPLE_W = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int COUNT_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SAMPLE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 8'd2;

  localparam logic FMT_PCM   = 1'b0;
  localparam logic FMT_FLOAT = 1'b1;

  localparam logic [SAMPLE_W-1:0] Q31_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] Q31_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    MODE_PCM8,
    MODE_PCM16,
    MODE_PCM24,
    MODE_PCM32,
    MODE_F32,
    MODE_F64,
    MODE_BAD
  } mode_t;

  function automatic mode_t mode_of(input logic fmt, input logic [6:0] bits);
    mode_t m;
    m = MODE_BAD;
    if (fmt == FMT_PCM) begin
      case (bits)
        7'd8:    m = MODE_PCM8;
        7'd16:   m = MODE_PCM16;
        7'd24:   m = MODE_PCM24;
        7'd32:   m = MODE_PCM32;
        default: m = MODE_BAD;
      endcase
    end else begin
      case (bits)
        7'd32:   m = MODE_F32;
        7'd64:   m = MODE_F64;
        default: m = MODE_BAD;
      endcase
    end
    return m;
  endfunction

endpackage

// ===== src/wfd_if.sv =====
// Stream and configuration interfaces of the frame decode and downmix block.
`timescale 1ns / 1ps

interface wfd_frame_if import wfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_0;
  logic [SLOT_W-1:0] slot_1;
  logic [SLOT_W-1:0] slot_2;
  logic [SLOT_W-1:0] slot_3;
  logic [SLOT_W-1:0] slot_4;
  logic [SLOT_W-1:0] slot_5;
  logic [SLOT_W-1:0] slot_6;
  logic [SLOT_W-1:0] slot_7;
  modport source (output valid, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, slot_6,
                  slot_7, input ready);
  modport sink (input valid, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, slot_6,
                slot_7, output ready);
endinterface

interface wfd_mono_if import wfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mono_sample;
  logic                       status;
  modport source (output valid, mono_sample, status, input ready);
  modport sink (input valid, mono_sample, status, output ready);
endinterface

interface wfd_cfg_if import wfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/wfd_lane_decode.sv =====
// Decoder of one channel slot into a signed Q1.31 sample.
`timescale 1ns / 1ps
module wfd_lane_decode import wfd_pkg::*; (
  input  logic [SLOT_W-1:0]   raw,
  input  mode_t               mode,
  output logic [SAMPLE_W-1:0] sample
);

  logic        neg32;
  logic [7:0]  e32;
  logic [7:0]  e32_adj;
  logic [30:0] m32;
  logic [7:0]  sh32;
  logic [30:0] mag32;
  logic        neg64;
  logic [10:0] e64;
  logic [10:0] e64_adj;
  logic [52:0] m64;
  logic [10:0] sh64;
  logic [52:0] mag64;

  always_comb begin
    neg32   = raw[31];
    e32     = raw[30:23];
    e32_adj = (e32 == 8'd0) ? 8'd1 : e32;
    // Mantissa pre-shifted by seven so that every exponent is a right shift.
    m32     = {(e32 != 8'd0), raw[22:0], 7'd0};
    sh32    = 8'd126 - e32_adj;
    mag32   = (sh32 >= 8'd31) ? 31'd0 : (m32 >> sh32[4:0]);

    neg64   = raw[63];
    e64     = raw[62:52];
    e64_adj = (e64 == 11'd0) ? 11'd1 : e64;
    m64     = {(e64 != 11'd0), raw[51:0]};
    sh64    = 11'd1044 - e64_adj;
    mag64   = (sh64 >= 11'd53) ? 53'd0 : (m64 >> sh64[5:0]);

    sample = '0;
    case (mode)
      MODE_PCM8:  sample = {~raw[7], raw[6:0], 24'd0};
      MODE_PCM16: sample = {raw[15:0], 16'd0};
      MODE_PCM24: sample = {raw[23:0], 8'd0};
      MODE_PCM32: sample = raw[31:0];
      MODE_F32: begin
        if (e32 == 8'hFF) begin
          sample = '0;
        end else if (e32 >= 8'd127) begin
          sample = neg32 ? Q31_MIN : Q31_MAX;
        end else begin
          sample = neg32 ? (32'd0 - {1'b0, mag32}) : {1'b0, mag32};
        end
      end
      MODE_F64: begin
        if (e64 == 11'h7FF) begin
          sample = '0;
        end else if (e64 >= 11'd1023) begin
          sample = neg64 ? Q31_MIN : Q31_MAX;
        end else begin
          sample = neg64 ? (32'd0 - {1'b0, mag64[30:0]}) : {1'b0, mag64[30:0]};
        end
      end
      default: sample = '0;
    endcase
  end

endmodule

// ===== src/wav_frame_decode_downmix_top.sv =====
// Top level of the WAV frame decode and downmix block.
// One frame of up to eight little-endian channel slots is taken per cycle unless the
// output is held, and one signed Q1.31 mono sample with a status bit comes out per
// frame, throughput one item per clock. There are nine register stages: a decode
// stage, a summing stage, six stages of a long division by the channel count (up to
// seven quotient bits each) and the output register. The whole pipeline holds when
// the result is not taken, so in ready follows the output side.
// Configuration must only change while the block is empty.
`timescale 1ns / 1ps
module wav_frame_decode_downmix_top import wfd_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  wfd_frame_if.sink  frame,
  wfd_mono_if.source mono,
  wfd_cfg_if.sink    cfg
);

  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_CHANNELS) + 1;
  localparam int DIV_STEP   = 7;
  localparam int DIV_STAGES = (SUM_W + DIV_STEP - 1) / DIV_STEP;

  logic                sample_format;
  logic [6:0]          bits_per_sample;
  logic [COUNT_W-1:0]  channel_count;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format   <= FMT_PCM;
      bits_per_sample <= 7'd16;
      channel_count   <= 4'd1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SAMPLE_FORMAT:   sample_format   <= cfg.data[0];
        REG_BITS_PER_SAMPLE: bits_per_sample <= cfg.data[6:0];
        REG_CHANNEL_COUNT:   channel_count   <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  mode_t              mode;
  logic [COUNT_W-1:0] n_eff;

  always_comb begin
    mode = mode_of(sample_format, bits_per_sample);
    if (channel_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (channel_count > COUNT_W'(MAX_CHANNELS)) begin
      n_eff = COUNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = channel_count;
    end
  end

  // Whole pipeline moves together; a full output register that is not taken holds it.
  logic en;
  assign en          = !mono.valid || mono.ready;
  assign frame.ready = en && !rst;

  logic [SLOT_W-1:0] slots [SLOTS];
  always_comb begin
    slots[0] = frame.slot_0;
    slots[1] = frame.slot_1;
    slots[2] = frame.slot_2;
    slots[3] = frame.slot_3;
    slots[4] = frame.slot_4;
    slots[5] = frame.slot_5;
    slots[6] = frame.slot_6;
    slots[7] = frame.slot_7;
  end

  // Decode stage.
  logic [SAMPLE_W-1:0] lane_dec [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] lane_q   [MAX_CHANNELS];
  logic                dec_valid;
  logic                dec_ok;
  logic [COUNT_W-1:0]  dec_n;

  for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
    wfd_lane_decode u_dec (
      .raw    (slots[l]),
      .mode   (mode),
      .sample (lane_dec[l])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        lane_q[l] <= (COUNT_W'(l) < n_eff && mode != MODE_BAD) ? lane_dec[l] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (en) begin
      dec_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_ok <= (mode != MODE_BAD);
      dec_n  <= n_eff;
    end
  end

  // Summing stage.
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] sum;
  logic                    sum_valid;
  logic                    sum_ok;
  logic [COUNT_W-1:0]      sum_n;

  always_comb begin
    sum_next = '0;
    for (int l = 0; l < MAX_CHANNELS; l++) begin
      sum_next = sum_next + SUM_W'(signed'(lane_q[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum    <= sum_next;
      sum_ok <= dec_ok;
      sum_n  <= dec_n;
    end
  end

  // Division stages: the dividend word has its processed bits replaced by quotient bits.
  logic [SUM_W-1:0]   dv_x     [DIV_STAGES+1];
  logic [COUNT_W-1:0] dv_rem   [DIV_STAGES];
  logic [COUNT_W-1:0] dv_n     [DIV_STAGES+1];
  logic               dv_neg   [DIV_STAGES+1];
  logic               dv_ok    [DIV_STAGES+1];
  logic               dv_valid [DIV_STAGES+1];

  always_comb begin
    dv_neg[0]   = sum[SUM_W-1];
    dv_x[0]     = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
    dv_rem[0]   = '0;
    dv_n[0]     = sum_n;
    dv_ok[0]    = sum_ok;
    dv_valid[0] = sum_valid;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [SUM_W-1:0]   x_next;
    logic [COUNT_W-1:0] rem_next;
    logic [COUNT_W:0]   trial;

    always_comb begin
      x_next   = dv_x[s];
      rem_next = dv_rem[s];
      trial    = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (SUM_W - 1 - (s * DIV_STEP + j) >= 0) begin
          trial = {rem_next, x_next[SUM_W - 1 - (s * DIV_STEP + j)]};
          if (trial >= {1'b0, dv_n[s]}) begin
            rem_next = COUNT_W'(trial - {1'b0, dv_n[s]});
            x_next[SUM_W - 1 - (s * DIV_STEP + j)] = 1'b1;
          end else begin
            rem_next = trial[COUNT_W-1:0];
            x_next[SUM_W - 1 - (s * DIV_STEP + j)] = 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s+1] <= 1'b0;
      end else if (en) begin
        dv_valid[s+1] <= dv_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_x[s+1]   <= x_next;
        dv_n[s+1]   <= dv_n[s];
        dv_neg[s+1] <= dv_neg[s];
        dv_ok[s+1]  <= dv_ok[s];
      end
    end

    // The last stage has no use for its remainder.
    if (s + 1 < DIV_STAGES) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[s+1] <= rem_next;
        end
      end
    end
  end

  // Output register.
  logic [SAMPLE_W-1:0] quot;
  assign quot = dv_x[DIV_STAGES][SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mono.valid <= 1'b0;
    end else if (en) begin
      mono.valid <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mono.mono_sample <= !dv_ok[DIV_STAGES] ? '0 :
                          (dv_neg[DIV_STAGES] ? (SAMPLE_W'(0) - quot) : quot);
      mono.status      <= !dv_ok[DIV_STAGES];
    end
  end

endmodule
